[hdl/slm_pkg.sv]
// Shared types and constants for the smoothstep layer mixer.
// Used by slm_lane, slm_merge, smoothstep_layer_mixer_unit and slm_checker.
package slm_pkg;

    localparam int LAYER_INPUTS = 4;
    localparam int VAL_W        = 16;
    localparam int PROD_W       = 33;
    localparam int SUM_W        = 36;

    localparam logic [15:0] ONE_Q15   = 16'd32768;
    localparam logic [16:0] THREE_Q15 = 17'd98304;
    localparam logic [47:0] HALF_Q30  = 48'd536870912;

    localparam logic signed [SUM_W-1:0] ROUND_Q15 = SUM_W'(16384);
    localparam logic signed [SUM_W-1:0] OUT_MIN   = -SUM_W'(32768);
    localparam logic signed [SUM_W-1:0] OUT_MAX   = SUM_W'(32767);

    typedef logic signed [VAL_W-1:0]  t_sample;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic [1:0]               t_lane_idx;

    // Per-stage advance strobes shared by all lanes.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_lane_en;

endpackage

[hdl/slm_lane.sv]
// One blend lane: triangle weight, smoothstep shaping and weighted sample.
// Depends on slm_pkg. Four register stages, advanced by the shared strobes.
module slm_lane (
    input  logic                i_clk,
    input  slm_pkg::t_lane_en   i_en,
    input  slm_pkg::t_lane_idx  i_lane_idx,
    input  logic                i_lane_on,
    input  logic [16:0]         i_u,
    input  slm_pkg::t_sample    i_sample,
    output slm_pkg::t_prod      o_prod
);
    import slm_pkg::*;

    logic signed [17:0] diff;
    logic [17:0]        span;
    logic               hit;
    logic [15:0]        n_ta;
    logic [15:0]        r_ta;
    t_sample            r_smp1;
    logic [31:0]        sq_full;
    logic [30:0]        r_sq;
    logic [16:0]        r_f;
    t_sample            r_smp2;
    logic [47:0]        p_full;
    logic [47:0]        p_rnd;
    logic [15:0]        r_ts;
    t_sample            r_smp3;
    t_prod              n_prod;
    t_prod              r_prod;

    // Distance from this lane's center on the blend axis.
    assign diff = $signed({1'b0, i_u}) - $signed({1'b0, i_lane_idx, 15'd0});
    assign span = diff[17] ? 18'(-diff) : 18'(diff);
    assign hit  = i_lane_on && (span <= {2'b00, ONE_Q15});
    // Zero weight shapes to zero, so drop out-of-reach lanes here.
    assign n_ta = hit ? 16'({2'b00, ONE_Q15} - span) : '0;

    assign sq_full = r_ta * r_ta;
    assign p_full  = r_sq * r_f;
    assign p_rnd   = p_full + HALF_Q30;
    assign n_prod  = $signed({1'b0, r_ts}) * r_smp3;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_ta   <= n_ta;
            r_smp1 <= i_sample;
        end
        if (i_en.s2) begin
            r_sq   <= sq_full[30:0];
            r_f    <= THREE_Q15 - {r_ta, 1'b0};
            r_smp2 <= r_smp1;
        end
        if (i_en.s3) begin
            r_ts   <= p_rnd[45:30];
            r_smp3 <= r_smp2;
        end
        if (i_en.s4) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[hdl/slm_merge.sv]
// Merge stage: sums the lane products, rounds half up and saturates.
// Depends on slm_pkg. One register stage.
module slm_merge #(
    parameter int LANES = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  slm_pkg::t_prod   i_prod [LANES],
    output slm_pkg::t_sample o_value
);
    import slm_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] rnd;
    logic signed [SUM_W-1:0] shifted;
    t_sample                 n_value;
    t_sample                 r_value;

    always_comb begin
        sum = '0;
        for (int i = 0; i < LANES; i++) begin
            sum = sum + SUM_W'(i_prod[i]);
        end
        rnd     = sum + ROUND_Q15;
        shifted = rnd >>> 15;
        priority if (shifted < OUT_MIN) begin
            n_value = OUT_MIN[VAL_W-1:0];
        end else if (shifted > OUT_MAX) begin
            n_value = OUT_MAX[VAL_W-1:0];
        end else begin
            n_value = shifted[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

[hdl/smoothstep_layer_mixer_unit.sv]
// Smoothstep layer mixer top: lane array, merge stage and pipeline control.
// Words pass the four lane stages, then the merge stage; one word per cycle
// sustained unless i_ready stalls, set by the five-stage stall-collapsing pipeline.
// Synchronous active-low reset clears all valid flags and sets active_layers to 4.
// Depends on slm_pkg, slm_lane and slm_merge.
module smoothstep_layer_mixer_unit #(
    parameter int MAX_LAYERS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [15:0]       i_blend_position,
    input  slm_pkg::t_sample  i_layer_value_0,
    input  slm_pkg::t_sample  i_layer_value_1,
    input  slm_pkg::t_sample  i_layer_value_2,
    input  slm_pkg::t_sample  i_layer_value_3,
    output logic              o_valid,
    input  logic              i_ready,
    output slm_pkg::t_sample  o_mixed_value
);
    import slm_pkg::*;

    localparam int LANE_CNT = (MAX_LAYERS < LAYER_INPUTS) ? MAX_LAYERS : LAYER_INPUTS;

    logic [2:0]  r_active_layers;
    logic [2:0]  layer_cnt;
    logic [1:0]  layer_m1;
    logic [15:0] pos_clamp;
    logic [16:0] u;
    t_sample     samples [LAYER_INPUTS];
    t_prod       prods   [LANE_CNT];
    logic [3:0]  r_vld;
    logic        r_out_valid;
    logic        en5;
    t_lane_en    en;

    assign samples[0] = i_layer_value_0;
    assign samples[1] = i_layer_value_1;
    assign samples[2] = i_layer_value_2;
    assign samples[3] = i_layer_value_3;

    always_comb begin
        priority if (r_active_layers < 3'd2) begin
            layer_cnt = 3'd2;
        end else if (r_active_layers > 3'(LANE_CNT)) begin
            layer_cnt = 3'(LANE_CNT);
        end else begin
            layer_cnt = r_active_layers;
        end
    end

    assign layer_m1  = 2'(layer_cnt - 3'd1);
    assign pos_clamp = (i_blend_position > ONE_Q15) ? ONE_Q15 : i_blend_position;
    assign u         = 17'({1'b0, pos_clamp} * {15'd0, layer_m1});

    // A stage advances when it is empty or the stage after it advances.
    assign en5     = !r_out_valid || i_ready;
    assign en.s4   = !r_vld[3] || en5;
    assign en.s3   = !r_vld[2] || en.s4;
    assign en.s2   = !r_vld[1] || en.s3;
    assign en.s1   = !r_vld[0] || en.s2;
    assign o_ready = en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_layers <= 3'd4;
            r_vld           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active_layers <= i_cfg_data;
            end
            if (en.s1) r_vld[0] <= i_valid;
            if (en.s2) r_vld[1] <= r_vld[0];
            if (en.s3) r_vld[2] <= r_vld[1];
            if (en.s4) r_vld[3] <= r_vld[2];
            if (en5)   r_out_valid <= r_vld[3];
        end
    end

    for (genvar k = 0; k < LANE_CNT; k++) begin : g_lane
        slm_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_lane_idx (2'(k)),
            .i_lane_on  (3'(k) < layer_cnt),
            .i_u        (u),
            .i_sample   (samples[k]),
            .o_prod     (prods[k])
        );
    end

    slm_merge #(
        .LANES (LANE_CNT)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (en5),
        .i_prod  (prods),
        .o_value (o_mixed_value)
    );

    assign o_valid = r_out_valid;

endmodule

[hdl/slm_checker.sv]
// Port-level checks for smoothstep_layer_mixer_unit, bound to the top level.
// Depends on slm_pkg for the word type.
module slm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input slm_pkg::t_sample o_mixed_value
);
    import slm_pkg::*;

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_mixed_value)))
        else $error("stalled output word changed");

    // Input backpressure only when every stage is full and the output stalls.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without output backpressure");

    // With the sink always ready, an accepted word passes every stage and reaches the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
            |=> o_valid)
        else $error("accepted word did not reach the output");

endmodule

bind smoothstep_layer_mixer_unit slm_checker u_slm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_mixed_value (o_mixed_value)
);
